// ===== rtl/core/erv3_pkg.sv =====
// Package: constants, types and helper functions of the Euler rotation unit.
package erv3_pkg;

  localparam int COORD_WIDTH  = 32;
  localparam int CORDIC_STEPS = 24;
  localparam int ANGLE_WIDTH  = 32;
  localparam int Q28_WIDTH    = 30;   // holds [-2^28, 2^28]
  localparam int CORDIC_WIDTH = 34;   // Q30 work width with headroom
  localparam int Z_WIDTH      = 34;
  localparam int ACC_WIDTH    = COORD_WIDTH + Q28_WIDTH + 4;

  localparam logic signed [34:0] Q28_PI      = 35'sd843314857;
  localparam logic signed [34:0] Q28_TWO_PI  = 35'sd1686629713;
  localparam logic signed [34:0] Q28_HALF_PI = 35'sd421657428;
  localparam logic signed [Q28_WIDTH-1:0] Q28_ONE = 30'sd268435456;

  localparam longint GAIN_INF  = 64'sd652032874;
  localparam longint GAIN_CORR = 64'sd434688583;
  localparam longint GAIN_VAL  = (2 * CORDIC_STEPS < 62) ?
      GAIN_INF + ((GAIN_CORR + (64'sd1 <<< (2 * CORDIC_STEPS - 1))) >>> (2 * CORDIC_STEPS))
      : GAIN_INF;
  localparam logic signed [CORDIC_WIDTH-1:0] CORDIC_GAIN = CORDIC_WIDTH'(GAIN_VAL);

  typedef logic signed [Q28_WIDTH-1:0]    q28_t;
  typedef logic signed [CORDIC_WIDTH-1:0] cval_t;
  typedef logic signed [Z_WIDTH-1:0]      zval_t;

  typedef struct packed {
    cval_t x;
    cval_t y;
    zval_t z;
    logic  neg;
  } cordic_state_t;

  typedef struct packed {
    q28_t s;
    q28_t c;
  } sincos_t;

  function automatic zval_t atan_q30(input int i);
    logic [31:0] v;
    case (i)
      0: v = 32'h3243F6A8;  1: v = 32'h1DAC6705;  2: v = 32'h0FADBAFC;
      3: v = 32'h07F56EA6;  4: v = 32'h03FEAB76;  5: v = 32'h01FFD55B;
      6: v = 32'h00FFFAAA;  7: v = 32'h007FFF55;  8: v = 32'h003FFFEA;
      9: v = 32'h001FFFFD; 10: v = 32'h000FFFFF; 11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF; 13: v = 32'h0001FFFF; 14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF; 16: v = 32'h00003FFF; 17: v = 32'h00001FFF;
      18: v = 32'h00000FFF; 19: v = 32'h000007FF; 20: v = 32'h000003FF;
      21: v = 32'h000001FF; 22: v = 32'h000000FF; 23: v = 32'h0000007F;
      24: v = 32'h0000003F; 25: v = 32'h0000001F; 26: v = 32'h0000000F;
      27: v = 32'h00000008; 28: v = 32'h00000004; 29: v = 32'h00000002;
      30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return zval_t'({2'b00, v});
  endfunction

  // Q28 product with round half up: floor((a*b + 2^27) / 2^28).
  function automatic q28_t qmul(input q28_t a, input q28_t b);
    logic signed [2*Q28_WIDTH-1:0] p;
    p = a * b + (2*Q28_WIDTH)'(64'sd134217728);
    return q28_t'(p >>> 28);
  endfunction

endpackage

// ===== rtl/core/euler_rotate_vector3_unit.sv =====
// Top level: pipelined Z-Y-X Euler rotation of a Q15.16 point.
//
// Usage:
//   Drive in_point_* and in_angle_about_* and raise start; an item is taken
//   at each rising edge with start high and busy low. busy is always low:
//   the pipeline takes one item every cycle, back to back.
//   Each result appears on out_rotated_* for exactly one cycle, marked by
//   out_valid. The receiver cannot stall, so nothing ever backs up.
// Stages from acceptance to out_valid: 1 reduction, one stage per CORDIC
//   step, 1 scaling, 2 matrix stages (pair products, then triple products
//   and sums), 1 coordinate product stage, 1 sum/round/saturate stage,
//   all fed by three parallel CORDIC pipes. Throughput: one item per
//   cycle, set by the fully pipelined CORDIC and multiplier stages.
// Reset: rst_n (synchronous, active low) clears the valid bits only;
//   no item in flight at reset produces a result.
// Angles are angle_about_x, negated angle_about_y, angle_about_z.
module euler_rotate_vector3_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [erv3_pkg::COORD_WIDTH-1:0] in_point_x,
  input  logic signed [erv3_pkg::COORD_WIDTH-1:0] in_point_y,
  input  logic signed [erv3_pkg::COORD_WIDTH-1:0] in_point_z,
  input  logic signed [erv3_pkg::ANGLE_WIDTH-1:0] in_angle_about_x,
  input  logic signed [erv3_pkg::ANGLE_WIDTH-1:0] in_angle_about_y,
  input  logic signed [erv3_pkg::ANGLE_WIDTH-1:0] in_angle_about_z,
  output logic                                out_valid,
  output logic signed [erv3_pkg::COORD_WIDTH-1:0] out_rotated_x,
  output logic signed [erv3_pkg::COORD_WIDTH-1:0] out_rotated_y,
  output logic signed [erv3_pkg::COORD_WIDTH-1:0] out_rotated_z
);
  localparam int CW    = erv3_pkg::COORD_WIDTH;
  localparam int QW    = erv3_pkg::Q28_WIDTH;
  localparam int AW    = erv3_pkg::ACC_WIDTH;
  localparam int SC_LAT = erv3_pkg::CORDIC_STEPS + 2;   // sincos pipe depth
  localparam int LAT   = SC_LAT + 4;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [CW+QW-1:0] prod_t;
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Valid bits travel alongside the data.
  logic [LAT-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], accept};
    end
  end

  // Point delay line matching the sincos pipe plus two matrix stages.
  localparam int PD = SC_LAT + 2;
  point_t pt_r [PD];
  always_ff @(posedge clk) begin
    pt_r[0] <= '{x: in_point_x, y: in_point_y, z: in_point_z};
    for (int k = 1; k < PD; k++) begin
      pt_r[k] <= pt_r[k-1];
    end
  end

  erv3_pkg::sincos_t sc_a, sc_b, sc_g;
  erv3_sincos u_sc_a (.clk(clk), .angle(in_angle_about_x), .result(sc_a));
  erv3_sincos u_sc_b (.clk(clk), .angle(in_angle_about_y), .result(sc_b));
  erv3_sincos u_sc_g (.clk(clk), .angle(in_angle_about_z), .result(sc_g));

  erv3_pkg::q28_t sa, ca, sb, cb, sg, cg;
  assign sa = sc_a.s;
  assign ca = sc_a.c;
  assign sb = -sc_b.s;
  assign cb = sc_b.c;
  assign sg = sc_g.s;
  assign cg = sc_g.c;

  // Matrix stage 1: pair products plus the factors the triples still need.
  erv3_pkg::q28_t m0_r, m3_r, m6_r, m7_r, m8_r;
  erv3_pkg::q28_t cgsa_r, casg_r, cacg_r, sasg_r, sasb_r, casb_r;
  erv3_pkg::q28_t sb_r, sg_r;
  always_ff @(posedge clk) begin
    m0_r   <= erv3_pkg::qmul(cb, cg);
    m3_r   <= erv3_pkg::qmul(cb, sg);
    m6_r   <= -sb;
    m7_r   <= erv3_pkg::qmul(cb, sa);
    m8_r   <= erv3_pkg::qmul(ca, cb);
    cgsa_r <= erv3_pkg::qmul(cg, sa);
    casg_r <= erv3_pkg::qmul(ca, sg);
    cacg_r <= erv3_pkg::qmul(ca, cg);
    sasg_r <= erv3_pkg::qmul(sa, sg);
    sasb_r <= erv3_pkg::qmul(sa, sb);
    casb_r <= erv3_pkg::qmul(ca, sb);
    sb_r   <= sb;
    sg_r   <= sg;
  end

  // Matrix stage 2: triple products and entry sums (Q28, narrow enough).
  erv3_pkg::q28_t m_r [9];
  always_ff @(posedge clk) begin
    m_r[0] <= m0_r;
    m_r[1] <= erv3_pkg::qmul(cgsa_r, sb_r) - casg_r;
    m_r[2] <= erv3_pkg::qmul(cacg_r, sb_r) + sasg_r;
    m_r[3] <= m3_r;
    m_r[4] <= cacg_r + erv3_pkg::qmul(sasb_r, sg_r);
    m_r[5] <= -cgsa_r + erv3_pkg::qmul(casb_r, sg_r);
    m_r[6] <= m6_r;
    m_r[7] <= m7_r;
    m_r[8] <= m8_r;
  end

  // Coordinate products, one register per product.
  prod_t pr_r [9];
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      pr_r[3*r]   <= pt_r[PD-1].x * m_r[3*r];
      pr_r[3*r+1] <= pt_r[PD-1].y * m_r[3*r+1];
      pr_r[3*r+2] <= pt_r[PD-1].z * m_r[3*r+2];
    end
  end

  // Exact row sum, round half up at bit 28, saturate.
  localparam logic signed [AW-1:0] ROUND_HALF = AW'(64'sd134217728);
  localparam logic signed [AW-1:0] SAT_MAX = AW'((64'sd1 <<< (CW - 1)) - 1);
  localparam logic signed [AW-1:0] SAT_MIN = -(AW'(64'sd1 <<< (CW - 1)));
  coord_t res_nxt [3];
  coord_t res_r [3];
  always_comb begin
    logic signed [AW-1:0] acc;
    for (int r = 0; r < 3; r++) begin
      acc = AW'(pr_r[3*r]) + AW'(pr_r[3*r+1]) + AW'(pr_r[3*r+2]) + ROUND_HALF;
      acc = acc >>> 28;
      if (acc > SAT_MAX) begin
        res_nxt[r] = coord_t'(SAT_MAX);
      end else if (acc < SAT_MIN) begin
        res_nxt[r] = coord_t'(SAT_MIN);
      end else begin
        res_nxt[r] = coord_t'(acc);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      res_r[r] <= res_nxt[r];
    end
  end

  assign out_valid     = vld_r[LAT-1];
  assign out_rotated_x = res_r[0];
  assign out_rotated_y = res_r[1];
  assign out_rotated_z = res_r[2];

  // Every accepted item comes out of the pipeline on out_valid; none is lost.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("item lost in pipeline");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(vld_r[LAT-2]))
    else $error("result without item");

  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("pipeline asserted busy");

endmodule

// ===== rtl/core/erv3_sincos.sv =====
// Pipelined CORDIC sine/cosine: reduction stage, one stage per step, scaling stage.
module erv3_sincos (
  input  logic                    clk,
  input  logic [erv3_pkg::ANGLE_WIDTH-1:0] angle,
  output erv3_pkg::sincos_t       result
);
  localparam int N = erv3_pkg::CORDIC_STEPS;

  erv3_pkg::cordic_state_t st_r [N+1];
  erv3_pkg::sincos_t       result_r;

  // Range reduction into [-pi/2, pi/2]; at most one 2*pi wrap for 32-bit Q28.
  logic signed [34:0] t0, t1;
  logic               neg;
  erv3_pkg::cordic_state_t st0_nxt;

  always_comb begin
    t0 = 35'(signed'(angle));
    if (t0 > erv3_pkg::Q28_PI) begin
      t0 = t0 - erv3_pkg::Q28_TWO_PI;
    end else if (t0 < -erv3_pkg::Q28_PI) begin
      t0 = t0 + erv3_pkg::Q28_TWO_PI;
    end
    neg = 1'b0;
    t1  = t0;
    if (t0 > erv3_pkg::Q28_HALF_PI) begin
      t1  = t0 - erv3_pkg::Q28_PI;
      neg = 1'b1;
    end else if (t0 < -erv3_pkg::Q28_HALF_PI) begin
      t1  = t0 + erv3_pkg::Q28_PI;
      neg = 1'b1;
    end
    st0_nxt.x   = erv3_pkg::CORDIC_GAIN;
    st0_nxt.y   = '0;
    st0_nxt.z   = erv3_pkg::zval_t'(t1 <<< 2);
    st0_nxt.neg = neg;
  end

  always_ff @(posedge clk) begin
    st_r[0] <= st0_nxt;
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    erv3_pkg::cordic_state_t step_nxt;
    always_comb begin
      step_nxt     = st_r[i];
      if (!st_r[i].z[erv3_pkg::Z_WIDTH-1]) begin
        step_nxt.x = st_r[i].x - (st_r[i].y >>> i);
        step_nxt.y = st_r[i].y + (st_r[i].x >>> i);
        step_nxt.z = st_r[i].z - erv3_pkg::atan_q30(i);
      end else begin
        step_nxt.x = st_r[i].x + (st_r[i].y >>> i);
        step_nxt.y = st_r[i].y - (st_r[i].x >>> i);
        step_nxt.z = st_r[i].z + erv3_pkg::atan_q30(i);
      end
    end
    always_ff @(posedge clk) begin
      st_r[i+1] <= step_nxt;
    end
  end

  // Sign fix, Q30 -> Q28 rounding, clamp to +-1.
  erv3_pkg::cval_t   xf, yf, xq, yq;
  erv3_pkg::sincos_t result_nxt;

  always_comb begin
    xf = st_r[N].neg ? -st_r[N].x : st_r[N].x;
    yf = st_r[N].neg ? -st_r[N].y : st_r[N].y;
    xq = (xf + erv3_pkg::cval_t'(2)) >>> 2;
    yq = (yf + erv3_pkg::cval_t'(2)) >>> 2;
    if (xq > erv3_pkg::cval_t'(erv3_pkg::Q28_ONE)) begin
      result_nxt.c = erv3_pkg::Q28_ONE;
    end else if (xq < -erv3_pkg::cval_t'(erv3_pkg::Q28_ONE)) begin
      result_nxt.c = -erv3_pkg::Q28_ONE;
    end else begin
      result_nxt.c = erv3_pkg::q28_t'(xq);
    end
    if (yq > erv3_pkg::cval_t'(erv3_pkg::Q28_ONE)) begin
      result_nxt.s = erv3_pkg::Q28_ONE;
    end else if (yq < -erv3_pkg::cval_t'(erv3_pkg::Q28_ONE)) begin
      result_nxt.s = -erv3_pkg::Q28_ONE;
    end else begin
      result_nxt.s = erv3_pkg::q28_t'(yq);
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
  end

  assign result = result_r;

endmodule

// ===== verif/euler_rotate_vector3_unit_test.sv =====
// Testbench for the Euler rotation unit: directed and random points checked against a predictor.
`timescale 1ns / 1ps

module euler_rotate_vector3_unit_test;

  localparam int W = erv3_pkg::COORD_WIDTH;
  localparam int LATENCY = erv3_pkg::CORDIC_STEPS + 6;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 550;

  // One rotated point.
  typedef struct {
    logic signed [W-1:0] x;
    logic signed [W-1:0] y;
    logic signed [W-1:0] z;
  } point_t;

  int errors = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Scoreboard: predicts each rotated point when its item is taken, checks
  // results in order.
  class rotation_scoreboard;
    point_t pending[$];

    static function longint floor_shift(input longint v, input int n);
      return v >>> n;
    endfunction

    static function longint atan_entry(input int i);
      longint t[32] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
        64'h00000001, 64'h00000000};
      return t[i];
    endfunction

    static function longint clip(input longint v, input longint lo, input longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Sine and cosine of a Q3.28 angle, Q28 out.
    static function void angle_sincos(input logic signed [31:0] ang,
                                      output longint s, output longint c);
      longint t, x, y, z, g, dx, dy;
      int n;
      bit flip;
      t = longint'(ang);
      flip = 0;
      n = erv3_pkg::CORDIC_STEPS < 1 ? 1 :
          (erv3_pkg::CORDIC_STEPS > 32 ? 32 : erv3_pkg::CORDIC_STEPS);
      for (int k = 0; k < 4 && t > 843314857; k++) t -= 1686629713;
      for (int k = 0; k < 4 && t < -843314857; k++) t += 1686629713;
      if (t > 421657428) begin
        t -= 843314857; flip = 1;
      end else if (t < -421657428) begin
        t += 843314857; flip = 1;
      end
      g = 652032874;
      if (2 * n < 62) g += (434688583 + (64'sd1 <<< (2 * n - 1))) >>> (2 * n);
      x = g; y = 0; z = t * 4;
      for (int i = 0; i < n; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_entry(i);
        end else begin
          x += dx; y -= dy; z += atan_entry(i);
        end
      end
      if (flip) begin
        x = -x; y = -y;
      end
      c = clip((x + 2) >>> 2, -268435456, 268435456);
      s = clip((y + 2) >>> 2, -268435456, 268435456);
    endfunction

    static function longint mul28(input longint a, input longint b);
      return (a * b + (64'sd1 <<< 27)) >>> 28;
    endfunction

    // Exact row dot product split in high and low coordinate halves.
    static function logic signed [W-1:0] row(input longint p[3], input longint e[3]);
      longint hi, lo, q, r;
      hi = 0; lo = 0;
      for (int j = 0; j < 3; j++) begin
        hi += (p[j] >>> 16) * e[j];
        lo += (p[j] & 64'hFFFF) * e[j];
      end
      q = hi + (lo >>> 16);
      r = lo & 64'hFFFF;
      q = (q + ((r + (64'sd1 <<< 27)) >>> 16)) >>> 12;
      return W'(clip(q, -(64'sd1 <<< (W - 1)), (64'sd1 <<< (W - 1)) - 1));
    endfunction

    function void note_item(input logic signed [W-1:0] px, py, pz,
                            input logic signed [31:0] ax, ay, az);
      longint sa, ca, sb, cb, sg, cg;
      longint p[3], m0[3], m1[3], m2[3];
      point_t r;
      angle_sincos(ax, sa, ca);
      angle_sincos(ay, sb, cb);
      sb = -sb;
      angle_sincos(az, sg, cg);
      p = '{longint'(px), longint'(py), longint'(pz)};
      m0 = '{mul28(cb, cg),
             mul28(mul28(cg, sa), sb) - mul28(ca, sg),
             mul28(mul28(ca, cg), sb) + mul28(sa, sg)};
      m1 = '{mul28(cb, sg),
             mul28(ca, cg) + mul28(mul28(sa, sb), sg),
             -mul28(cg, sa) + mul28(mul28(ca, sb), sg)};
      m2 = '{-sb, mul28(cb, sa), mul28(ca, cb)};
      r.x = row(p, m0);
      r.y = row(p, m1);
      r.z = row(p, m2);
      pending.push_back(r);
    endfunction

    task check_result(input logic signed [W-1:0] gx, gy, gz);
      point_t e;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing pending", gx, 0);
        return;
      end
      e = pending.pop_front();
      if (gx !== e.x) report_mismatch("rotated_x", gx, e.x);
      if (gy !== e.y) report_mismatch("rotated_y", gy, e.y);
      if (gz !== e.z) report_mismatch("rotated_z", gz, e.z);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic signed [W-1:0] in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic signed [31:0] in_angle_about_x = '0, in_angle_about_y = '0, in_angle_about_z = '0;
  logic out_valid;
  logic signed [W-1:0] out_rotated_x, out_rotated_y, out_rotated_z;

  rotation_scoreboard board = new();
  int idle_pct = 0;   // sender idle percentage for the current phase
  int quiet_cycles = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  euler_rotate_vector3_unit dut (
    .clk, .rst_n, .start, .busy,
    .in_point_x, .in_point_y, .in_point_z,
    .in_angle_about_x, .in_angle_about_y, .in_angle_about_z,
    .out_valid, .out_rotated_x, .out_rotated_y, .out_rotated_z
  );

  // Sample both handshakes at the rising edge; the watchdog counts cycles
  // in which nothing moves.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        board.note_item(in_point_x, in_point_y, in_point_z,
                        in_angle_about_x, in_angle_about_y, in_angle_about_z);
      end
      if (out_valid) board.check_result(out_rotated_x, out_rotated_y, out_rotated_z);
      if ((start && !busy) || out_valid) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Present one item from the falling edge and hold it until it is taken.
  // Random idle cycles go in front of it according to the phase.
  task automatic send_item(input logic signed [W-1:0] px, py, pz,
                           input logic signed [31:0] ax, ay, az);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(negedge clk);
    end
    in_point_x <= px; in_point_y <= py; in_point_z <= pz;
    in_angle_about_x <= ax; in_angle_about_y <= ay; in_angle_about_z <= az;
    start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Random angle: mostly within one turn, sometimes any 32-bit value or a
  // point near the reduction boundaries.
  function automatic logic signed [31:0] pick_angle();
    int sel;
    sel = $urandom_range(9);
    if (sel < 5) return 32'($signed($urandom_range(1686629713)) - 843314857);
    if (sel < 8) return $urandom;
    case ($urandom_range(3))
      0: return 32'(843314857 + $signed($urandom_range(4)) - 2);
      1: return 32'(-843314857 + $signed($urandom_range(4)) - 2);
      2: return 32'(421657428 + $signed($urandom_range(4)) - 2);
      default: return 32'(-421657428 + $signed($urandom_range(4)) - 2);
    endcase
  endfunction

  // Random coordinate: mostly moderate, sometimes full range to saturate.
  function automatic logic signed [W-1:0] pick_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return W'($signed($urandom_range(2000000)) - 1000000);
      2: return W'($signed($urandom_range(200000000)) - 100000000);
      default: return $urandom_range(1) ? {1'b0, {(W-1){1'b1}}} : {1'b1, {(W-1){1'b0}}};
    endcase
  endfunction

  localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [31:0] AMAX = 32'h7FFF_FFFF;
  localparam logic signed [31:0] AMIN = 32'h8000_0000;
  localparam logic signed [31:0] PI_A = 32'sd843314857;
  localparam logic signed [31:0] HPI_A = 32'sd421657428;

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: identity, axis turns, half-turn folds, far angles, saturation.
    send_item(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 0, 0, 0);
    send_item(32'sh0001_0000, 0, 0, 0, 0, HPI_A);
    send_item(0, 32'sh0001_0000, 0, HPI_A, 0, 0);
    send_item(0, 0, 32'sh0001_0000, 0, HPI_A, 0);
    send_item(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, PI_A, PI_A, PI_A);
    send_item(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, -PI_A, -PI_A, -PI_A);
    send_item(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, HPI_A + 1, -HPI_A - 1, HPI_A);
    send_item(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, -HPI_A, HPI_A + 1, -HPI_A - 1);
    send_item(32'sh0005_8000, -32'sh0003_4000, 32'sh0000_0001, AMAX, AMIN, AMAX);
    send_item(32'sh1234_5678, 32'sh0765_4321, -32'sh0ABC_DEF0, AMIN, AMAX, AMIN);
    send_item(CMAX, CMAX, CMAX, 0, 0, 0);
    send_item(CMIN, CMIN, CMIN, 0, 0, 0);
    send_item(CMAX, CMAX, CMAX, 32'sd210828714, 32'sd210828714, 32'sd210828714);
    send_item(CMIN, CMIN, CMIN, -32'sd210828714, 32'sd210828714, -32'sd210828714);
    send_item(CMAX, CMIN, CMAX, PI_A, 0, HPI_A);
    send_item(-1, -1, -1, 32'sd1, -32'sd1, 32'sd1);
    send_item(32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF);

    // Drain before the random part so nothing is in flight.
    start <= 0;
    while (board.pending.size() != 0) @(negedge clk);

    // Random phases: back to back, sender idle 56 of 100, then 16.
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 0 : (ph == 1 ? 56 : 16);
      for (int i = 0; i < RANDOM_ITEMS / 3; i++) begin
        send_item(pick_coord(), pick_coord(), pick_coord(),
                  pick_angle(), pick_angle(), pick_angle());
      end
    end

    start <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/erv3_pkg.sv
rtl/core/erv3_sincos.sv
rtl/core/euler_rotate_vector3_unit.sv
verif/euler_rotate_vector3_unit_test.sv
